// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the rate limiter RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Expression that must never hold outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ----- hw/rtl/mwrl_pkg.sv -----
// Shared types and constants for the mecanum wheel rate limiter.
// No dependencies; used by the interfaces, the lanes and the top level.
package mwrl_pkg;

    localparam int WHEELS     = 4;
    localparam int ROT_W      = 16;   // rotate_lever, Q0.16
    localparam int GAIN_W     = 16;   // speed_to_wheel_gain, Q8.8
    localparam int LIM_W      = 17;   // max_wheel_rate
    localparam int STEP_W     = 17;   // slew_step
    localparam int GAIN_SHIFT = 8;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 17;
    localparam int CNT_W      = $clog2(LIM_W);

    localparam logic [ROT_W-1:0]  ROT_RST  = 16'd16384;
    localparam logic [GAIN_W-1:0] GAIN_RST = 16'd3000;
    localparam logic [LIM_W-1:0]  LIM_RST  = 17'd65536;
    localparam logic [STEP_W-1:0] STEP_RST = 17'd410;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROTATE_LEVER = 4'd0,
        CFG_WHEEL_GAIN   = 4'd1,
        CFG_MAX_RATE     = 4'd2,
        CFG_SLEW_STEP    = 4'd3
    } t_cfg_idx;

    // Sequencer controls for one serial lane.
    typedef struct packed {
        logic load;
        logic step;
    } t_lane_ctrl;

endpackage

// ----- hw/rtl/mwrl_if.sv -----
// Valid/ready channel interfaces of the rate limiter: command, wheel result, config write.
// Depends on mwrl_pkg for the config field widths.
interface mwrl_cmd_if #(parameter int RATE_WIDTH = 18);
    logic                         valid;
    logic                         ready;
    logic signed [RATE_WIDTH-1:0] forward_speed;
    logic signed [RATE_WIDTH-1:0] lateral_speed;
    logic signed [RATE_WIDTH-1:0] yaw_rate;
    logic                         stop;
    modport source (output valid, forward_speed, lateral_speed, yaw_rate, stop,
                    input ready);
    modport sink (input valid, forward_speed, lateral_speed, yaw_rate, stop,
                  output ready);
endinterface

interface mwrl_wheel_if #(parameter int RATE_WIDTH = 18);
    logic                         valid;
    logic                         ready;
    logic signed [RATE_WIDTH-1:0] front_left_rate;
    logic signed [RATE_WIDTH-1:0] front_right_rate;
    logic signed [RATE_WIDTH-1:0] rear_left_rate;
    logic signed [RATE_WIDTH-1:0] rear_right_rate;
    logic                         desaturated;
    modport source (output valid, front_left_rate, front_right_rate, rear_left_rate,
                    rear_right_rate, desaturated, input ready);
    modport sink (input valid, front_left_rate, front_right_rate, rear_left_rate,
                  rear_right_rate, desaturated, output ready);
endinterface

interface mwrl_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [mwrl_pkg::CFG_IDX_W-1:0]  index;
    logic [mwrl_pkg::CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/mwrl_smul.sv -----
// Serial signed-by-unsigned multiplier lane, two multiplier bits per cycle, MSB first.
// Depends on mwrl_pkg for the lane control struct.
module mwrl_smul #(
    parameter int A_W = 20,
    parameter int B_W = 16,
    parameter int P_W = 37
) (
    input  logic                   i_clk,
    input  mwrl_pkg::t_lane_ctrl   i_ctrl,
    input  logic signed [A_W-1:0]  i_a,
    input  logic [B_W-1:0]         i_b,
    output logic signed [P_W-1:0]  o_p
);

    logic signed [A_W-1:0] r_a;
    logic [B_W-1:0]        r_b;
    logic signed [P_W-1:0] r_acc;
    logic signed [P_W-1:0] n_acc;
    logic signed [P_W-1:0] a_ext;
    logic signed [P_W-1:0] pp;
    logic [1:0]            digit;

    always_comb begin
        digit = r_b[B_W-1:B_W-2];
        a_ext = P_W'(r_a);
        pp    = (digit[1] ? (a_ext <<< 1) : '0) + (digit[0] ? a_ext : '0);
        n_acc = (r_acc <<< 2) + pp;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
        end else if (i_ctrl.step) begin
            r_acc <= n_acc;
            r_b   <= r_b << 2;
        end
    end

    assign o_p = r_acc;

endmodule

// ----- hw/rtl/mwrl_scale.sv -----
// Serial scale lane: q = trunc(mag * lim / div), one lim bit per cycle, MSB first.
// Needs mag <= div and div > 0. Depends on mwrl_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mwrl_scale #(
    parameter int M_W = 28,
    parameter int L_W = 17
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  mwrl_pkg::t_lane_ctrl i_ctrl,
    input  logic [M_W-1:0]       i_mag,
    input  logic [L_W-1:0]       i_lim,
    input  logic [M_W-1:0]       i_div,
    output logic [L_W-1:0]       o_q
);

    logic [M_W-1:0] r_mag;
    logic [M_W-1:0] r_div;
    logic [L_W-1:0] r_l;
    logic [M_W-1:0] r_rem;
    logic [L_W-1:0] r_q;
    logic [M_W+1:0] t;
    logic [M_W+1:0] div1;
    logic [M_W+1:0] div2;
    logic [M_W+1:0] n_rem;
    logic [1:0]     k;
    logic [L_W-1:0] n_q;

    // Invariant: mag * lim_so_far = q * div + rem, rem < div, so t < 3 * div.
    always_comb begin
        div1 = (M_W+2)'(r_div);
        div2 = (M_W+2)'({r_div, 1'b0});
        t    = (M_W+2)'({r_rem, 1'b0}) + (r_l[L_W-1] ? (M_W+2)'(r_mag) : '0);
        priority if (t >= div2) begin
            n_rem = t - div2;
            k     = 2'd2;
        end else if (t >= div1) begin
            n_rem = t - div1;
            k     = 2'd1;
        end else begin
            n_rem = t;
            k     = 2'd0;
        end
        n_q = L_W'({r_q, 1'b0} + (L_W+1)'(k));
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_mag <= i_mag;
            r_div <= i_div;
            r_l   <= i_lim;
            r_rem <= '0;
            r_q   <= '0;
        end else if (i_ctrl.step) begin
            r_rem <= M_W'(n_rem);
            r_q   <= n_q;
            r_l   <= r_l << 1;
        end
    end

    assign o_q = r_q;

    `ASSERT_CLK(a_rem_below_div, i_clk, i_rst_n, i_ctrl.step |=> (r_rem < r_div), "scale remainder not below divisor")

endmodule

// ----- hw/rtl/mecanum_wheel_rate_limiter_top.sv -----
// Mecanum wheel rate limiter: X-pattern inverse kinematics, desaturation and slew.
// Channels: i_cmd (body command words in), o_wheel (wheel rate words out), i_cfg
// (register writes, always ready; write only while the block is idle).
// One result word per command word. After i_cmd is taken, ready stays low while
// the word works through the serial lanes: the lever product (two bits per
// cycle), a step to form the wheel sums, the gain products, a step to find the
// largest wheel, the scale lanes only when the limit is exceeded (one limit bit
// per cycle), and a step to slew and load the output register. A stop word goes
// straight to that last step. i_cmd.ready returns the cycle after the result
// is loaded, so the next word may enter while the result still waits in the
// output register.
// If o_wheel stalls with a result already waiting, the finished word holds in
// the slew step until the output register frees; held targets update then.
// Reset (i_rst_n low, synchronous) restores register defaults, clears the held
// targets and drops o_wheel.valid. Interfaces must use RATE_WIDTH as well.
// Depends on mwrl_pkg, mwrl_if, mwrl_smul, mwrl_scale and assert_macros.svh.
`include "assert_macros.svh"

module mecanum_wheel_rate_limiter_top #(
    parameter int RATE_WIDTH = 18
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    mwrl_cmd_if.sink      i_cmd,
    mwrl_wheel_if.source  o_wheel,
    mwrl_cfg_if.sink      i_cfg
);

    localparam int W     = RATE_WIDTH;
    localparam int LP_W  = W + mwrl_pkg::ROT_W + 1;
    localparam int S_W   = W + 2;
    localparam int WP_W  = S_W + mwrl_pkg::GAIN_W + 1;
    localparam int WW    = WP_W - mwrl_pkg::GAIN_SHIFT;
    localparam int AW    = WW - 1;
    localparam int DW    = ((W + 1 > mwrl_pkg::STEP_W + 1) ? W + 1 : mwrl_pkg::STEP_W + 1) + 1;
    localparam int NW    = mwrl_pkg::WHEELS;
    localparam int LEVER_STEPS = mwrl_pkg::ROT_W / 2;
    localparam int GAIN_STEPS  = mwrl_pkg::GAIN_W / 2;

    typedef enum logic [2:0] {
        S_IDLE, S_LEVER, S_LOAD, S_WHEEL, S_MAX, S_SCALE, S_SLEW
    } t_state;

    t_state r_state;
    logic [mwrl_pkg::CNT_W-1:0]  r_cnt;
    logic [mwrl_pkg::ROT_W-1:0]  r_rotate_lever;
    logic [mwrl_pkg::GAIN_W-1:0] r_gain;
    logic [mwrl_pkg::LIM_W-1:0]  r_max_rate;
    logic [mwrl_pkg::STEP_W-1:0] r_slew_step;
    logic signed [W-1:0] r_fwd;
    logic signed [W-1:0] r_lat;
    logic                r_stop;
    logic                r_desat;
    logic signed [W-1:0] r_held [NW];
    logic signed [W-1:0] r_out_rate [NW];
    logic                r_out_desat;
    logic                r_out_valid;

    logic cmd_acc;
    logic cfg_acc;
    logic out_free;
    logic out_load;
    logic out_zero;
    mwrl_pkg::t_lane_ctrl lever_ctrl, wheel_ctrl, scale_ctrl;

    logic signed [LP_W-1:0] lever_p;
    logic signed [W:0]      lever;
    logic signed [S_W-1:0]  fx, rx, lx;
    logic signed [S_W-1:0]  s_in [NW];
    logic signed [WP_W-1:0] w_acc [NW];
    logic signed [WW-1:0]   w [NW];
    logic [AW-1:0]          mag [NW];
    logic [AW-1:0]          m01, m23, mx;
    logic                   desat_now;
    logic [mwrl_pkg::LIM_W-1:0] q [NW];
    logic signed [WW-1:0]   tgt_wide [NW];
    logic signed [W-1:0]    tgt [NW];
    logic signed [DW-1:0]   d [NW];
    logic signed [DW-1:0]   stepx;
    logic signed [W-1:0]    n_held [NW];

    assign cmd_acc     = i_cmd.valid && i_cmd.ready;
    assign cfg_acc     = i_cfg.valid && i_cfg.ready;
    assign out_free    = !r_out_valid || o_wheel.ready;
    assign out_load    = (r_state == S_SLEW) && out_free;
    assign i_cmd.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    assign lever_ctrl.load = cmd_acc;
    assign lever_ctrl.step = (r_state == S_LEVER);
    assign wheel_ctrl.load = (r_state == S_LOAD);
    assign wheel_ctrl.step = (r_state == S_WHEEL);
    assign scale_ctrl.load = (r_state == S_MAX);
    assign scale_ctrl.step = (r_state == S_SCALE);

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rotate_lever <= mwrl_pkg::ROT_RST;
            r_gain         <= mwrl_pkg::GAIN_RST;
            r_max_rate     <= mwrl_pkg::LIM_RST;
            r_slew_step    <= mwrl_pkg::STEP_RST;
        end else if (cfg_acc) begin
            unique case (i_cfg.index)
                mwrl_pkg::CFG_ROTATE_LEVER: r_rotate_lever <= i_cfg.data[mwrl_pkg::ROT_W-1:0];
                mwrl_pkg::CFG_WHEEL_GAIN:   r_gain <= i_cfg.data[mwrl_pkg::GAIN_W-1:0];
                mwrl_pkg::CFG_MAX_RATE:     r_max_rate <= i_cfg.data[mwrl_pkg::LIM_W-1:0];
                mwrl_pkg::CFG_SLEW_STEP:    r_slew_step <= i_cfg.data[mwrl_pkg::STEP_W-1:0];
                default: ;
            endcase
        end
    end

    mwrl_smul #(.A_W(W), .B_W(mwrl_pkg::ROT_W), .P_W(LP_W)) u_lever (
        .i_clk  (i_clk),
        .i_ctrl (lever_ctrl),
        .i_a    (i_cmd.yaw_rate),
        .i_b    (r_rotate_lever),
        .o_p    (lever_p)
    );

    // Wheel sums; left wheels negated.
    always_comb begin
        lever   = lever_p[LP_W-1:mwrl_pkg::ROT_W];
        fx      = S_W'(r_fwd);
        rx      = S_W'(r_lat);
        lx      = S_W'(lever);
        s_in[0] = -(fx + rx + lx);
        s_in[1] = fx - rx - lx;
        s_in[2] = rx - fx - lx;
        s_in[3] = fx + rx - lx;
    end

    for (genvar g = 0; g < NW; g++) begin : g_lane
        mwrl_smul #(.A_W(S_W), .B_W(mwrl_pkg::GAIN_W), .P_W(WP_W)) u_wheel (
            .i_clk  (i_clk),
            .i_ctrl (wheel_ctrl),
            .i_a    (s_in[g]),
            .i_b    (r_gain),
            .o_p    (w_acc[g])
        );

        mwrl_scale #(.M_W(AW), .L_W(mwrl_pkg::LIM_W)) u_scale (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (scale_ctrl),
            .i_mag   (mag[g]),
            .i_lim   (r_max_rate),
            .i_div   (mx),
            .o_q     (q[g])
        );
    end

    // Magnitudes, largest wheel, saturation and slew per wheel.
    always_comb begin
        for (int i = 0; i < NW; i++) begin
            w[i]   = w_acc[i][WP_W-1:mwrl_pkg::GAIN_SHIFT];
            mag[i] = w[i][WW-1] ? AW'(-w[i]) : AW'(w[i]);
        end
        m01       = (mag[0] > mag[1]) ? mag[0] : mag[1];
        m23       = (mag[2] > mag[3]) ? mag[2] : mag[3];
        mx        = (m01 > m23) ? m01 : m23;
        desat_now = mx > AW'(r_max_rate);
        stepx     = $signed(DW'(r_slew_step));
        for (int i = 0; i < NW; i++) begin
            if (r_desat) begin
                tgt_wide[i] = w[i][WW-1] ? -$signed(WW'(q[i])) : $signed(WW'(q[i]));
            end else begin
                tgt_wide[i] = w[i];
            end
            if ((&tgt_wide[i][WW-1:W-1]) || !(|tgt_wide[i][WW-1:W-1])) begin
                tgt[i] = tgt_wide[i][W-1:0];
            end else if (tgt_wide[i][WW-1]) begin
                tgt[i] = {1'b1, {(W-1){1'b0}}};
            end else begin
                tgt[i] = {1'b0, {(W-1){1'b1}}};
            end
            d[i] = DW'(tgt[i]) - DW'(r_held[i]);
            priority if (d[i] > stepx) begin
                n_held[i] = W'(DW'(r_held[i]) + stepx);
            end else if (d[i] < -stepx) begin
                n_held[i] = W'(DW'(r_held[i]) - stepx);
            end else begin
                n_held[i] = tgt[i];
            end
        end
    end

    // Sequencer, held targets and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NW; i++) begin
                r_held[i] <= '0;
            end
        end else begin
            // Drop valid once taken, unless a new word loads in the same cycle.
            if (o_wheel.ready && !out_load) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (cmd_acc) begin
                        r_fwd   <= i_cmd.forward_speed;
                        r_lat   <= i_cmd.lateral_speed;
                        r_stop  <= i_cmd.stop;
                        r_cnt   <= '0;
                        r_state <= i_cmd.stop ? S_SLEW : S_LEVER;
                    end
                end
                S_LEVER: begin
                    if (r_cnt == mwrl_pkg::CNT_W'(LEVER_STEPS - 1)) begin
                        r_cnt   <= '0;
                        r_state <= S_LOAD;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_LOAD: begin
                    r_state <= S_WHEEL;
                end
                S_WHEEL: begin
                    if (r_cnt == mwrl_pkg::CNT_W'(GAIN_STEPS - 1)) begin
                        r_cnt   <= '0;
                        r_state <= S_MAX;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_MAX: begin
                    r_desat <= desat_now;
                    r_cnt   <= '0;
                    r_state <= desat_now ? S_SCALE : S_SLEW;
                end
                S_SCALE: begin
                    if (r_cnt == mwrl_pkg::CNT_W'(mwrl_pkg::LIM_W - 1)) begin
                        r_cnt   <= '0;
                        r_state <= S_SLEW;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_SLEW: begin
                    // Hold the finished word until the output register frees.
                    if (out_free) begin
                        for (int i = 0; i < NW; i++) begin
                            r_held[i]     <= r_stop ? '0 : n_held[i];
                            r_out_rate[i] <= r_stop ? '0 : n_held[i];
                        end
                        r_out_desat <= r_stop ? 1'b0 : r_desat;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
            endcase
        end
    end

    assign o_wheel.valid            = r_out_valid;
    assign o_wheel.front_left_rate  = r_out_rate[0];
    assign o_wheel.front_right_rate = r_out_rate[1];
    assign o_wheel.rear_left_rate   = r_out_rate[2];
    assign o_wheel.rear_right_rate  = r_out_rate[3];
    assign o_wheel.desaturated      = r_out_desat;

    assign out_zero = (r_out_rate[0] == '0) && (r_out_rate[1] == '0) &&
                      (r_out_rate[2] == '0) && (r_out_rate[3] == '0) && !r_out_desat;

    `ASSERT_CLK(a_stop_zero, i_clk, i_rst_n, (out_load && r_stop) |=> out_zero, "stop not zero")
    `ASSERT_CLK(a_load_slew, i_clk, i_rst_n, $rose(r_out_valid) |-> $past(out_load), "stray load")
    `ASSERT_NEVER(a_scale_desat, i_clk, i_rst_n, (r_state == S_SCALE) && !r_desat, "stray scale")

endmodule
